// File: hdl/ptom_pkg.sv
package ptom_pkg;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_CANCEL = 1'b1;

  localparam logic [1:0] TYPE_LIMIT  = 2'd0;
  localparam logic [1:0] TYPE_MARKET = 2'd1;
  localparam logic [1:0] TYPE_FOK    = 2'd2;
  localparam logic [1:0] TYPE_NONE   = 2'd3;

  localparam logic [2:0] ST_RESTED    = 3'd0;
  localparam logic [2:0] ST_FILLED    = 3'd1;
  localparam logic [2:0] ST_DROPPED   = 3'd2;
  localparam logic [2:0] ST_CANCELLED = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_BOOK_FULL = 3'd5;

  localparam logic KIND_TRADE = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  typedef enum logic [1:0] {
    BK_NOP,
    BK_INSERT,
    BK_FILL,
    BK_CANCEL
  } book_op_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] price;
    logic [31:0] qty;
    logic [31:0] rem;
  } trade_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic cancel;
    logic drop;
    logic scan_step;
    logic fill;
    logic finish;
    logic load_trade;
    logic load_final;
    logic emit_next;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       is_cancel;
    logic [1:0] order_type;
    logic       fill_ok;
    logic       scan_stop;
    logic       fok_go;
    logic       emit_more;
  } dp_stat_t;

  function automatic logic crosses(input logic side, input logic [1:0] otype,
                                   input logic [31:0] limit, input logic [31:0] rest);
    logic r;
    if (otype == TYPE_MARKET) r = 1'b1;
    else if (side) r = (rest >= limit);
    else r = (rest <= limit);
    return r;
  endfunction

endpackage

// File: hdl/ptom_book.sv
module ptom_book import ptom_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      sell,
  input  book_op_t                  op,
  input  logic [31:0]               c_price,
  input  logic [31:0]               c_qty,
  input  logic [31:0]               c_id,
  input  logic [$clog2(DEPTH+1)-1:0] rd_idx,
  output logic [31:0]               head_price,
  output logic [31:0]               head_qty,
  output logic [31:0]               head_id,
  output logic                      head_vld,
  output logic                      full,
  output logic                      found,
  output logic [31:0]               rd_price,
  output logic [31:0]               rd_qty,
  output logic                      rd_vld
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [31:0] price_r [DEPTH];
  logic [31:0] qty_r   [DEPTH];
  logic [31:0] id_r    [DEPTH];
  logic [DEPTH-1:0] vld_r;

  logic [31:0] price_nxt [DEPTH];
  logic [31:0] qty_nxt   [DEPTH];
  logic [31:0] id_nxt    [DEPTH];
  logic [DEPTH-1:0] vld_nxt;

  logic [DEPTH-1:0] keep;
  logic [DEPTH-1:0] match;
  logic [DEPTH-1:0] hit;
  logic head_done;

  assign head_price = price_r[0];
  assign head_qty   = qty_r[0];
  assign head_id    = id_r[0];
  assign head_vld   = vld_r[0];
  assign full       = vld_r[DEPTH-1];
  assign found      = |match;
  assign head_done  = (qty_r[0] == c_qty);

  assign rd_vld   = (rd_idx < CW'(DEPTH)) && vld_r[rd_idx[IW-1:0]];
  assign rd_price = price_r[rd_idx[IW-1:0]];
  assign rd_qty   = qty_r[rd_idx[IW-1:0]];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic       from_prev;
    logic       take_new;
    logic       from_next;
    logic [31:0] nx_price, nx_qty, nx_id;
    logic        nx_vld;

    assign keep[g]  = vld_r[g] && (sell ? (price_r[g] <= c_price) : (price_r[g] >= c_price));
    assign match[g] = vld_r[g] && (id_r[g] == c_id);

    if (g == 0) begin : g_first
      assign hit[g]    = match[g];
      assign take_new  = !keep[g];
      assign from_prev = 1'b0;
    end else begin : g_rest
      assign hit[g]    = hit[g-1] | match[g];
      assign take_new  = !keep[g] && keep[g-1];
      assign from_prev = !keep[g] && !keep[g-1];
    end

    if (g == DEPTH-1) begin : g_last
      assign nx_price = price_r[g];
      assign nx_qty   = qty_r[g];
      assign nx_id    = id_r[g];
      assign nx_vld   = 1'b0;
    end else begin : g_mid
      assign nx_price = price_r[g+1];
      assign nx_qty   = qty_r[g+1];
      assign nx_id    = id_r[g+1];
      assign nx_vld   = vld_r[g+1];
    end

    always_comb begin
      price_nxt[g] = price_r[g];
      qty_nxt[g]   = qty_r[g];
      id_nxt[g]    = id_r[g];
      vld_nxt[g]   = vld_r[g];
      from_next    = 1'b0;
      unique case (op)
        BK_INSERT: begin
          if (take_new) begin
            price_nxt[g] = c_price;
            qty_nxt[g]   = c_qty;
            id_nxt[g]    = c_id;
          end else if (from_prev) begin
            if (g > 0) begin
              price_nxt[g] = price_r[(g > 0) ? g-1 : 0];
              qty_nxt[g]   = qty_r[(g > 0) ? g-1 : 0];
              id_nxt[g]    = id_r[(g > 0) ? g-1 : 0];
            end
          end
          vld_nxt[g] = vld_r[g] || (g == 0) || vld_r[(g > 0) ? g-1 : 0];
        end
        BK_FILL: begin
          if (head_done) from_next = 1'b1;
          else if (g == 0) qty_nxt[g] = qty_r[g] - c_qty;
        end
        BK_CANCEL: from_next = hit[g];
        default: ;
      endcase
      if (from_next) begin
        price_nxt[g] = nx_price;
        qty_nxt[g]   = nx_qty;
        id_nxt[g]    = nx_id;
        vld_nxt[g]   = nx_vld;
      end
    end

    always_ff @(posedge clk) begin
      price_r[g] <= price_nxt[g];
      qty_r[g]   <= qty_nxt[g];
      id_r[g]    <= id_nxt[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= vld_nxt;
  end

endmodule

// File: hdl/ptom_datapath.sv
module ptom_datapath import ptom_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic        in_op,
  input  logic [31:0] in_order_id,
  input  logic        in_side,
  input  logic [1:0]  in_order_type,
  input  logic [31:0] in_price,
  input  logic [31:0] in_quantity,
  output logic        out_kind,
  output logic [2:0]  out_status,
  output logic [31:0] out_resting_id,
  output logic [31:0] out_trade_price,
  output logic [31:0] out_trade_quantity,
  output logic [31:0] out_remaining_quantity,
  output logic [31:0] out_best_bid_price,
  output logic        out_best_bid_valid,
  output logic [31:0] out_best_ask_price,
  output logic        out_best_ask_valid,
  output logic        out_last
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic        op_r;
  logic [31:0] id_r;
  logic        side_r;
  logic [1:0]  type_r;
  logic [31:0] price_r;
  logic [31:0] rem_r, rem_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [32:0] sum_r, sum_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic [CW-1:0] ntr_r, ntr_nxt;
  logic [CW-1:0] eidx_r, eidx_nxt;

  trade_t trade_mem [DEPTH];
  trade_t rd_r;

  book_op_t bid_op, ask_op;
  logic [31:0] bid_hp, bid_hq, bid_hi, ask_hp, ask_hq, ask_hi;
  logic bid_hv, ask_hv, bid_full, ask_full, bid_found, ask_found;
  logic [31:0] bid_rp, bid_rq, ask_rp, ask_rq;
  logic bid_rv, ask_rv;

  logic [31:0] opp_hp, opp_hq, opp_hi, opp_rp, opp_rq, amt, ins_qty;
  logic opp_hv, opp_rv, own_full;
  book_op_t ins_op;

  ptom_book #(.DEPTH(DEPTH)) u_bid (
    .clk, .rst_n, .sell(1'b0), .op(bid_op),
    .c_price(price_r), .c_qty(ins_qty), .c_id(id_r), .rd_idx(scan_r),
    .head_price(bid_hp), .head_qty(bid_hq), .head_id(bid_hi), .head_vld(bid_hv),
    .full(bid_full), .found(bid_found),
    .rd_price(bid_rp), .rd_qty(bid_rq), .rd_vld(bid_rv)
  );

  ptom_book #(.DEPTH(DEPTH)) u_ask (
    .clk, .rst_n, .sell(1'b1), .op(ask_op),
    .c_price(price_r), .c_qty(ins_qty), .c_id(id_r), .rd_idx(scan_r),
    .head_price(ask_hp), .head_qty(ask_hq), .head_id(ask_hi), .head_vld(ask_hv),
    .full(ask_full), .found(ask_found),
    .rd_price(ask_rp), .rd_qty(ask_rq), .rd_vld(ask_rv)
  );

  assign opp_hp   = side_r ? bid_hp : ask_hp;
  assign opp_hq   = side_r ? bid_hq : ask_hq;
  assign opp_hi   = side_r ? bid_hi : ask_hi;
  assign opp_hv   = side_r ? bid_hv : ask_hv;
  assign opp_rp   = side_r ? bid_rp : ask_rp;
  assign opp_rq   = side_r ? bid_rq : ask_rq;
  assign opp_rv   = side_r ? bid_rv : ask_rv;
  assign own_full = side_r ? ask_full : bid_full;
  assign amt      = (rem_r < opp_hq) ? rem_r : opp_hq;
  // the same data bus carries fill amount or the resting quantity
  assign ins_qty  = cmd.fill ? amt : rem_r;

  assign stat.is_cancel  = op_r;
  assign stat.order_type = type_r;
  assign stat.fill_ok    = (rem_r != '0) && opp_hv && crosses(side_r, type_r, price_r, opp_hp);
  assign stat.scan_stop  = !opp_rv || !crosses(side_r, type_r, price_r, opp_rp)
                           || (sum_r >= {1'b0, rem_r});
  assign stat.fok_go     = (sum_r >= {1'b0, rem_r});
  assign stat.emit_more  = (eidx_r < ntr_r);

  always_comb begin
    ins_op = BK_NOP;
    if (cmd.finish && rem_r != '0 && type_r == TYPE_LIMIT && !own_full) ins_op = BK_INSERT;
    bid_op = BK_NOP;
    ask_op = BK_NOP;
    if (cmd.cancel) begin
      bid_op = BK_CANCEL;
      if (!bid_found) ask_op = BK_CANCEL;
    end else if (cmd.fill) begin
      if (side_r) bid_op = BK_FILL;
      else ask_op = BK_FILL;
    end else if (side_r) ask_op = ins_op;
    else bid_op = ins_op;
  end

  always_comb begin
    rem_nxt    = rem_r;
    status_nxt = status_r;
    sum_nxt    = sum_r;
    scan_nxt   = scan_r;
    ntr_nxt    = ntr_r;
    eidx_nxt   = eidx_r;
    if (cmd.capture) begin
      rem_nxt  = in_quantity;
      sum_nxt  = '0;
      scan_nxt = '0;
      ntr_nxt  = '0;
      eidx_nxt = '0;
    end
    if (cmd.cancel) begin
      rem_nxt    = '0;
      status_nxt = (bid_found || ask_found) ? ST_CANCELLED : ST_NOT_FOUND;
    end
    if (cmd.drop) status_nxt = ST_DROPPED;
    if (cmd.scan_step) begin
      sum_nxt  = sum_r + {1'b0, opp_rq};
      scan_nxt = scan_r + 1'b1;
    end
    if (cmd.fill) begin
      rem_nxt = rem_r - amt;
      ntr_nxt = ntr_r + 1'b1;
    end
    if (cmd.finish) begin
      if (rem_r == '0) status_nxt = ST_FILLED;
      else if (type_r == TYPE_LIMIT) status_nxt = own_full ? ST_BOOK_FULL : ST_RESTED;
      else status_nxt = ST_DROPPED;
    end
    if (cmd.emit_next) eidx_nxt = eidx_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_op;
      id_r    <= in_order_id;
      side_r  <= in_side;
      type_r  <= in_order_type;
      price_r <= in_price;
    end
    rem_r    <= rem_nxt;
    status_r <= status_nxt;
    sum_r    <= sum_nxt;
    scan_r   <= scan_nxt;
    ntr_r    <= ntr_nxt;
    eidx_r   <= eidx_nxt;
  end

  // trade log, replayed once the books have settled
  always_ff @(posedge clk) begin
    if (cmd.fill) trade_mem[ntr_r[IW-1:0]] <= '{id: opp_hi, price: opp_hp, qty: amt,
                                                rem: rem_r - amt};
    rd_r <= trade_mem[eidx_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_trade || cmd.load_final) begin
      out_best_bid_price <= bid_hv ? bid_hp : '0;
      out_best_bid_valid <= bid_hv;
      out_best_ask_price <= ask_hv ? ask_hp : '0;
      out_best_ask_valid <= ask_hv;
    end
    if (cmd.load_trade) begin
      out_kind               <= KIND_TRADE;
      out_status             <= ST_RESTED;
      out_resting_id         <= rd_r.id;
      out_trade_price        <= rd_r.price;
      out_trade_quantity     <= rd_r.qty;
      out_remaining_quantity <= rd_r.rem;
      out_last               <= 1'b0;
    end else if (cmd.load_final) begin
      out_kind               <= KIND_FINAL;
      out_status             <= status_r;
      out_resting_id         <= '0;
      out_trade_price        <= '0;
      out_trade_quantity     <= '0;
      out_remaining_quantity <= rem_r;
      out_last               <= 1'b1;
    end
  end

endmodule

// File: hdl/ptom_ctrl.sv
module ptom_ctrl import ptom_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_MATCH = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_LOAD  = 3'd5;
  localparam logic [2:0] S_SHOW  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       final_r, final_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_SHOW);

  always_comb begin
    state_nxt = state_r;
    final_nxt = final_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.is_cancel) begin
          cmd.cancel = 1'b1;
          state_nxt  = S_RD;
        end else if (stat.order_type == TYPE_NONE) begin
          cmd.drop  = 1'b1;
          state_nxt = S_RD;
        end else if (stat.order_type == TYPE_FOK) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_MATCH;
        end
      end
      S_SCAN: begin
        // sum crossing quantity until it covers the order, the book runs out or the cross ends
        if (stat.scan_stop) begin
          if (stat.fok_go) state_nxt = S_MATCH;
          else begin
            cmd.drop  = 1'b1;
            state_nxt = S_RD;
          end
        end else cmd.scan_step = 1'b1;
      end
      S_MATCH: begin
        if (stat.fill_ok) cmd.fill = 1'b1;
        else begin
          cmd.finish = 1'b1;
          state_nxt  = S_RD;
        end
      end
      S_RD: begin
        if (stat.emit_more) begin
          final_nxt = 1'b0;
          state_nxt = S_LOAD;
        end else begin
          cmd.load_final = 1'b1;
          final_nxt      = 1'b1;
          state_nxt      = S_SHOW;
        end
      end
      S_LOAD: begin
        cmd.load_trade = 1'b1;
        state_nxt      = S_SHOW;
      end
      S_SHOW: begin
        if (!out_stall) begin
          if (final_r) state_nxt = S_IDLE;
          else begin
            cmd.emit_next = 1'b1;
            state_nxt     = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      final_r <= final_nxt;
    end
  end

endmodule

// File: hdl/price_time_order_matcher_top.sv
// Price-time order matcher: a bid book and an ask book of BOOK_DEPTH resting orders each,
// held as sorted register chains so an insert, a cancel or a head fill updates a whole chain
// at once. One item is processed at a time. An add is dispatched and then matched against
// the head of the opposite book, one fill at a time; a fill or kill order first sums crossing
// quantity over the resting orders, and when it is killed it skips the match state. A cancel
// or an unused order type goes straight to the replay. All results are then replayed from a
// trade log, each record held until taken, after which the next item is accepted.
// Every record carries the best bid and ask after the whole item.
module price_time_order_matcher_top import ptom_pkg::*; #(
  parameter int BOOK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [31:0] in_order_id,
  input  logic        in_side,
  input  logic [1:0]  in_order_type,
  input  logic [31:0] in_price,
  input  logic [31:0] in_quantity,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [2:0]  out_status,
  output logic [31:0] out_resting_id,
  output logic [31:0] out_trade_price,
  output logic [31:0] out_trade_quantity,
  output logic [31:0] out_remaining_quantity,
  output logic [31:0] out_best_bid_price,
  output logic        out_best_bid_valid,
  output logic [31:0] out_best_ask_price,
  output logic        out_best_ask_valid,
  output logic        out_last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ptom_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
  );

  ptom_datapath #(.DEPTH(BOOK_DEPTH)) u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_op, .in_order_id, .in_side, .in_order_type, .in_price, .in_quantity,
    .out_kind, .out_status, .out_resting_id, .out_trade_price, .out_trade_quantity,
    .out_remaining_quantity, .out_best_bid_price, .out_best_bid_valid,
    .out_best_ask_price, .out_best_ask_valid, .out_last
  );

endmodule

// File: dv/tb_price_time_order_matcher_top.sv
`timescale 1ns / 100ps

typedef struct packed {
  logic        kind;
  logic [2:0]  status;
  logic [31:0] rid;
  logic [31:0] tprice;
  logic [31:0] tqty;
  logic [31:0] rem;
  logic [31:0] bbp;
  logic        bbv;
  logic [31:0] bap;
  logic        bav;
  logic        last;
} sb_rec_t;

class book_scoreboard;
  localparam int DEPTH = 32;

  logic [31:0] px[2][$];
  logic [31:0] qt[2][$];
  logic [31:0] oid[2][$];
  sb_rec_t pending_records[$];
  int errors;
  int trades_seen;
  int finals_seen;

  function new();
    errors = 0;
    trades_seen = 0;
    finals_seen = 0;
  endfunction

  function logic [31:0] best_price(int s);
    return px[s].size() > 0 ? px[s][0] : 32'd0;
  endfunction

  function logic crossing(logic sd, logic [1:0] ty, logic [31:0] lim, logic [31:0] rest);
    if (ty == ptom_pkg::TYPE_MARKET) return 1'b1;
    return sd ? (rest >= lim) : (rest <= lim);
  endfunction

  // apply one order to the book mirror and queue the records it should produce
  function void note_order(logic op, logic [31:0] id, logic sd, logic [1:0] ty,
                           logic [31:0] pr, logic [31:0] qn);
    sb_rec_t recs[$];
    sb_rec_t r;
    logic [31:0] rem;
    logic [31:0] amt;
    logic [2:0] st;
    logic [63:0] sum;
    bit found;
    bit go;
    int o;
    int pos;
    rem = qn;
    found = 0;
    if (op == ptom_pkg::OP_CANCEL) begin
      for (int s = 0; s < 2 && !found; s++) begin
        for (int k = 0; k < px[s].size(); k++) begin
          if (oid[s][k] == id) begin
            px[s].delete(k); qt[s].delete(k); oid[s].delete(k);
            found = 1;
            break;
          end
        end
      end
      st = found ? ptom_pkg::ST_CANCELLED : ptom_pkg::ST_NOT_FOUND;
      rem = 0;
    end else if (ty == ptom_pkg::TYPE_NONE) begin
      st = ptom_pkg::ST_DROPPED;
    end else begin
      o = sd ? 0 : 1;
      go = 1;
      if (ty == ptom_pkg::TYPE_FOK) begin
        sum = 0;
        for (int k = 0; k < px[o].size() && crossing(sd, ty, pr, px[o][k]); k++)
          sum += qt[o][k];
        go = sum >= {32'd0, rem};
      end
      while (go && rem != 0 && recs.size() < DEPTH && px[o].size() > 0 &&
             crossing(sd, ty, pr, px[o][0])) begin
        amt = rem < qt[o][0] ? rem : qt[o][0];
        rem -= amt;
        qt[o][0] -= amt;
        r = '0;
        r.rid = oid[o][0];
        r.tprice = px[o][0];
        r.tqty = amt;
        r.rem = rem;
        recs = {recs, r};
        if (qt[o][0] == 0) begin
          px[o].delete(0); qt[o].delete(0); oid[o].delete(0);
        end
      end
      if (rem == 0) st = ptom_pkg::ST_FILLED;
      else if (ty == ptom_pkg::TYPE_LIMIT) begin
        if (px[sd].size() >= DEPTH) st = ptom_pkg::ST_BOOK_FULL;
        else begin
          pos = 0;
          while (pos < px[sd].size() && (sd ? px[sd][pos] <= pr : px[sd][pos] >= pr)) pos++;
          px[sd].insert(pos, pr);
          qt[sd].insert(pos, rem);
          oid[sd].insert(pos, id);
          st = ptom_pkg::ST_RESTED;
        end
      end else st = ptom_pkg::ST_DROPPED;
    end
    r = '0;
    r.kind = ptom_pkg::KIND_FINAL;
    r.status = st;
    r.rem = rem;
    r.last = 1'b1;
    recs = {recs, r};
    foreach (recs[k]) begin
      recs[k].bbp = best_price(0);
      recs[k].bbv = px[0].size() > 0;
      recs[k].bap = best_price(1);
      recs[k].bav = px[1].size() > 0;
      pending_records = {pending_records, recs[k]};
    end
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  task check_record(sb_rec_t got);
    sb_rec_t w;
    if (pending_records.size() == 0) begin
      report("unexpected record", got.rem, 0);
      return;
    end
    w = pending_records.pop_front();
    if (got.kind == ptom_pkg::KIND_TRADE) trades_seen++;
    else finals_seen++;
    if (got.kind !== w.kind) report("kind", got.kind, w.kind);
    if (got.status !== w.status) report("status", got.status, w.status);
    if (got.rid !== w.rid) report("resting_id", got.rid, w.rid);
    if (got.tprice !== w.tprice) report("trade_price", got.tprice, w.tprice);
    if (got.tqty !== w.tqty) report("trade_quantity", got.tqty, w.tqty);
    if (got.rem !== w.rem) report("remaining_quantity", got.rem, w.rem);
    if (got.bbp !== w.bbp) report("best_bid_price", got.bbp, w.bbp);
    if (got.bbv !== w.bbv) report("best_bid_valid", got.bbv, w.bbv);
    if (got.bap !== w.bap) report("best_ask_price", got.bap, w.bap);
    if (got.bav !== w.bav) report("best_ask_valid", got.bav, w.bav);
    if (got.last !== w.last) report("last", got.last, w.last);
  endtask
endclass

module tb_price_time_order_matcher_top;
  import ptom_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_op;
  logic [31:0] in_order_id;
  logic        in_side;
  logic [1:0]  in_order_type;
  logic [31:0] in_price;
  logic [31:0] in_quantity;
  logic        out_valid;
  logic        out_stall;
  logic        out_kind;
  logic [2:0]  out_status;
  logic [31:0] out_resting_id;
  logic [31:0] out_trade_price;
  logic [31:0] out_trade_quantity;
  logic [31:0] out_remaining_quantity;
  logic [31:0] out_best_bid_price;
  logic        out_best_bid_valid;
  logic [31:0] out_best_ask_price;
  logic        out_best_ask_valid;
  logic        out_last;

  book_scoreboard book_sb;
  int idle_cycles;
  int orders_sent;
  int cancels_sent;
  logic [31:0] recent_ids[$];
  bit stall_quiet;

  price_time_order_matcher_top dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_op = 0;
    in_order_id = 0;
    in_side = 0;
    in_order_type = 0;
    in_price = 0;
    in_quantity = 0;
    out_stall = 0;
  end

  // result side: random stall between beats, with quiet stretches
  initial begin
    int wait_n;
    sb_rec_t r;
    stall_quiet = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        r.kind = out_kind;
        r.status = out_status;
        r.rid = out_resting_id;
        r.tprice = out_trade_price;
        r.tqty = out_trade_quantity;
        r.rem = out_remaining_quantity;
        r.bbp = out_best_bid_price;
        r.bbv = out_best_bid_valid;
        r.bap = out_best_ask_price;
        r.bav = out_best_ask_valid;
        r.last = out_last;
        book_sb.check_record(r);
        wait_n = stall_quiet ? 0 : $urandom_range(0, 10);
        if (wait_n > 0) begin
          @(negedge clk);
          out_stall <= 1;
          repeat (wait_n - 1) @(negedge clk);
          @(negedge clk);
          out_stall <= 0;
        end
      end
    end
  end

  // watchdog on cycles with no accepted beat on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog expired, %0d records outstanding",
               book_sb.pending_records.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // valid stays high into the next beat when there is no gap
  task send_order(logic op, logic [31:0] id, logic sd, logic [1:0] ty,
                  logic [31:0] pr, logic [31:0] qn, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_op <= op;
    in_order_id <= id;
    in_side <= sd;
    in_order_type <= ty;
    in_price <= pr;
    in_quantity <= qn;
    do @(posedge clk); while (in_stall);
    book_sb.note_order(op, id, sd, ty, pr, qn);
    if (op == OP_CANCEL) cancels_sent++;
    else begin
      orders_sent++;
      recent_ids = {recent_ids, id};
      if (recent_ids.size() > 64) void'(recent_ids.pop_front());
    end
    @(negedge clk);
  endtask

  task send_add(logic [31:0] id, logic sd, logic [1:0] ty, logic [31:0] pr, logic [31:0] qn);
    send_order(OP_ADD, id, sd, ty, pr, qn, 1'b0);
  endtask

  logic [31:0] mid;
  logic [31:0] cid;
  logic [1:0] ty;
  int pick;

  initial begin
    book_sb = new();
    orders_sent = 0;
    cancels_sent = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: empty-book cases, crossing, fok, zero qty, unused type, cancels
    send_order(OP_CANCEL, 32'hFFFF_FFFF, 1'b1, TYPE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_add(32'd1, 1'b0, TYPE_MARKET, 32'd0, 32'd10);
    send_add(32'd2, 1'b0, TYPE_LIMIT, 32'd100, 32'd5);
    send_add(32'd3, 1'b0, TYPE_LIMIT, 32'd100, 32'd7);
    send_add(32'd4, 1'b0, TYPE_LIMIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_add(32'd5, 1'b1, TYPE_LIMIT, 32'd0, 32'd0);
    send_add(32'd6, 1'b1, TYPE_NONE, 32'd50, 32'd9);
    send_add(32'd7, 1'b1, TYPE_LIMIT, 32'd200, 32'd3);
    send_add(32'd8, 1'b1, TYPE_FOK, 32'd100, 32'hFFFF_FFFF);
    send_add(32'd9, 1'b1, TYPE_FOK, 32'd100, 32'd20);
    send_add(32'd10, 1'b1, TYPE_LIMIT, 32'd90, 32'd10);
    send_add(32'd11, 1'b0, TYPE_MARKET, 32'd0, 32'd100);
    send_add(32'd12, 1'b1, TYPE_LIMIT, 32'd0, 32'd4);
    send_order(OP_CANCEL, 32'd12, 1'b0, TYPE_LIMIT, 32'd0, 32'd0, 1'b0);
    send_order(OP_CANCEL, 32'd12, 1'b0, TYPE_LIMIT, 32'd0, 32'd0, 1'b0);
    // fill the bid book to depth, then one more rest must report book full
    for (int k = 0; k < 33; k++)
      send_order(OP_ADD, 32'h100 + k, 1'b0, TYPE_LIMIT, 32'd10 + 32'(k % 5), 32'd1, k > 20);
    // a sweep of the whole bid book
    send_add(32'hAAAA_5555, 1'b1, TYPE_MARKET, 32'hFFFF_FFFF, 32'd1000);

    // random: prices near a mid so books cross often
    mid = 32'd1000;
    for (int n = 0; n < 160; n++) begin
      if (n == 100) stall_quiet = 1;
      if (n == 140) stall_quiet = 0;
      pick = $urandom_range(0, 99);
      if (pick < 12 && recent_ids.size() > 0) begin
        cid = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
        send_order(OP_CANCEL, cid, 1'($urandom), 2'($urandom), $urandom, $urandom,
                   stall_quiet);
      end else if (pick < 15) begin
        send_order(OP_CANCEL, $urandom, 1'($urandom), 2'($urandom), $urandom, $urandom,
                   stall_quiet);
      end else if (pick < 20) begin
        // wide values to toggle every field bit
        send_order(OP_ADD, $urandom, 1'($urandom), 2'($urandom), $urandom, $urandom,
                   stall_quiet);
      end else begin
        pick = $urandom_range(0, 9);
        ty = pick < 6 ? TYPE_LIMIT : (pick < 8 ? TYPE_MARKET : TYPE_FOK);
        send_order(OP_ADD, $urandom_range(0, 300), 1'($urandom), ty,
                   mid - 32'd20 + $urandom_range(0, 40), $urandom_range(0, 60), stall_quiet);
      end
    end
    in_valid <= 0;

    while (book_sb.pending_records.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d adds and %0d cancels; checked %0d trade and %0d final records",
             orders_sent, cancels_sent, book_sb.trades_seen, book_sb.finals_seen);
    if (book_sb.errors == 0 && book_sb.pending_records.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d records missing", book_sb.errors,
               book_sb.pending_records.size());
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// File: price_time_order_matcher_top.f
hdl/ptom_pkg.sv
hdl/ptom_book.sv
hdl/ptom_datapath.sv
hdl/ptom_ctrl.sv
hdl/price_time_order_matcher_top.sv
dv/tb_price_time_order_matcher_top.sv
